### rtl/swg_pkg.sv
// Shared types, constants, sigmoid table and rounding helpers for the SwiGLU unit.
package swg_pkg;

   localparam int FRAC_BITS       = 10;
   localparam int SIGMOID_ENTRIES = 256;
   localparam int CLAMP_LIMIT     = 15;

   localparam int DATA_W   = 16;
   localparam int WIDE_W   = 64;
   localparam int ONE      = 1 << FRAC_BITS;
   localparam int HALF_ONE = ONE / 2;
   localparam int LIM      = CLAMP_LIMIT << FRAC_BITS;
   localparam int HALF_LIM = LIM / 2;
   localparam int LIM_W    = $clog2(LIM + 1);
   localparam int MAG_W    = (DATA_W + 1 > LIM_W) ? DATA_W + 1 : LIM_W;
   localparam int IDX_W    = $clog2(SIGMOID_ENTRIES + 1);
   localparam int ROM_W    = FRAC_BITS + 1;
   localparam int S_W      = FRAC_BITS + 2;

   // table position a*ENTRIES/LIM, split by reciprocal multiply plus one correction
   localparam int     POS_W   = $clog2(LIM * SIGMOID_ENTRIES + 1);
   localparam longint RCP1    = (longint'(1) << POS_W) / LIM;
   localparam int     PROD1_W = POS_W + IDX_W;

   // interpolation (delta*r + LIM/2) / LIM, same scheme
   localparam int     NUM_W   = ROM_W + LIM_W + 1;
   localparam longint RCP2    = (longint'(1) << NUM_W) / LIM;
   localparam int     Q2_W    = ROM_W + 1;
   localparam int     PROD2_W = NUM_W + Q2_W;

   localparam int XS_W  = DATA_W + S_W;
   localparam int GG_W  = 2 * DATA_W;
   localparam int T_W   = XS_W + S_W;
   localparam int XSG_W = XS_W + DATA_W;
   localparam int SD_W  = T_W + 2 - FRAC_BITS;
   localparam int GX_W  = GG_W + SD_W;

   localparam int FRONT_DEPTH = 4;
   localparam int OUT_DEPTH   = 16;
   localparam int PIPE_STAGES = 12;

   localparam longint DATA_MAX = (longint'(1) << (DATA_W - 1)) - 1;
   localparam longint DATA_MIN = -(longint'(1) << (DATA_W - 1));

   localparam logic [63:0] Q30_ONE = 64'd1 << 30;

   typedef enum logic {
      MODE_FWD = 1'b0,
      MODE_BWD = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type                  mode;
      logic signed [DATA_W-1:0]  x;
      logic signed [DATA_W-1:0]  gate;
      logic signed [DATA_W-1:0]  grad;
      logic                      x_neg;
   } carry_type;

   typedef struct packed {
      carry_type         c;
      logic [LIM_W-1:0]  x_abs;
   } front_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     clip;
   } sat_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] primary;
      logic signed [DATA_W-1:0] dgate;
      logic                     saturated;
   } result_type;

   typedef logic [ROM_W-1:0] sig_rom_type [0:SIGMOID_ENTRIES];

   // elaboration-time helpers for building the table
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         if (r >= d) begin
            r    = r - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] exp_pos_q30(input logic [63:0] f);
      logic [63:0] term;
      logic [63:0] sum;
      term = Q30_ONE;
      sum  = Q30_ONE;
      for (int k = 1; k <= 24; k++) begin
         term = udiv64((term * f) >> 30, 64'(k));
         sum  = sum + term;
      end
      return sum;
   endfunction

   function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
      logic [63:0] e;
      e = exp_pos_q30(f);
      return udiv64((64'd1 << 60) + (e >> 1), e);
   endfunction

   function automatic sig_rom_type build_sig_rom();
      sig_rom_type rom;
      logic [63:0] einv1;
      logic [63:0] tq;
      logic [63:0] n;
      logic [63:0] em;
      logic [63:0] den;
      einv1 = exp_neg_q30(Q30_ONE);
      for (int i = 0; i <= SIGMOID_ENTRIES; i++) begin
         tq = ((64'(i) * 64'(CLAMP_LIMIT)) << 30) / 64'(SIGMOID_ENTRIES);
         n  = tq >> 30;
         em = exp_neg_q30(tq & (Q30_ONE - 64'd1));
         for (int k = 0; k < 64; k++) begin
            if (64'(k) < n) begin
               em = (em * einv1 + (Q30_ONE >> 1)) >> 30;
            end
         end
         den    = Q30_ONE + em;
         rom[i] = ROM_W'(udiv64((64'd1 << (FRAC_BITS + 30)) + (den >> 1), den));
      end
      return rom;
   endfunction

   localparam sig_rom_type SIG_ROM = build_sig_rom();

   // round to nearest, ties up; equals floor((v + 2^(sh-1)) / 2^sh)
   function automatic logic signed [WIDE_W-1:0] rnd_shift(
      input logic signed [WIDE_W-1:0] v,
      input int                       sh
   );
      logic signed [WIDE_W-1:0] w;
      w = v + (WIDE_W'(1) <<< (sh - 1));
      return w >>> sh;
   endfunction

   function automatic sat_type sat_data(input logic signed [WIDE_W-1:0] v);
      sat_type r;
      r.clip  = 1'b0;
      r.value = DATA_W'(v);
      if (v > DATA_MAX) begin
         r.clip  = 1'b1;
         r.value = DATA_W'(DATA_MAX);
      end
      if (v < DATA_MIN) begin
         r.clip  = 1'b1;
         r.value = DATA_W'(DATA_MIN);
      end
      return r;
   endfunction

   function automatic sat_type rnd_sat(input logic signed [WIDE_W-1:0] v, input int sh);
      return sat_data(rnd_shift(v, sh));
   endfunction

endpackage

### rtl/swg_front.sv
// Front end: accepts items, clamps x for the sigmoid and queues them for the back end.
module swg_front
   import swg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  mode_type                  mode,
   input  logic                      req_push,
   input  logic signed [DATA_W-1:0]  req_x_in,
   input  logic signed [DATA_W-1:0]  req_gate_in,
   input  logic signed [DATA_W-1:0]  req_grad_in,
   output logic                      req_full,
   input  logic                      q_pop,
   output logic                      q_empty,
   output front_item_type            q_item
);

   localparam int PTR_W = $clog2(FRONT_DEPTH);
   localparam int CNT_W = $clog2(FRONT_DEPTH + 1);

   front_item_type    slot_ff [FRONT_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   front_item_type    item;
   logic [MAG_W-1:0]  mag;
   logic              push_ok;
   logic              pop_ok;

   // |x| clamped to the table range; sign is kept separately
   always_comb begin
      item.c.mode  = mode;
      item.c.x     = req_x_in;
      item.c.gate  = req_gate_in;
      item.c.grad  = req_grad_in;
      item.c.x_neg = req_x_in[DATA_W-1];
      mag = req_x_in[DATA_W-1] ? MAG_W'(-$signed({req_x_in[DATA_W-1], req_x_in}))
                               : MAG_W'({1'b0, req_x_in});
      item.x_abs = (mag > MAG_W'(LIM)) ? LIM_W'(LIM) : LIM_W'(mag);
   end

   assign req_full = (count_ff == CNT_W'(FRONT_DEPTH));
   assign q_empty  = (count_ff == '0);
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = q_pop && !q_empty;
   assign q_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_ok) - CNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

### rtl/swg_back.sv
// Back end: sigmoid interpolation, products, rounding, saturation and the result queue.
module swg_back
   import swg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  front_item_type            q_item,
   input  logic                      q_empty,
   output logic                      q_pop,
   input  logic                      rsp_pop,
   output logic                      rsp_empty,
   output logic signed [DATA_W-1:0]  rsp_primary_out,
   output logic signed [DATA_W-1:0]  rsp_dgate_out,
   output logic                      rsp_saturated
);

   localparam int PTR_W = $clog2(OUT_DEPTH);
   localparam int CNT_W = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      carry_type         c;
      logic [POS_W-1:0]  pos;
   } st1_type;

   typedef struct packed {
      carry_type         c;
      logic [POS_W-1:0]  pos;
      logic [IDX_W-1:0]  est;
   } st2_type;

   typedef struct packed {
      carry_type         c;
      logic [IDX_W-1:0]  idx;
      logic [LIM_W-1:0]  r;
   } st3_type;

   typedef struct packed {
      carry_type         c;
      logic [ROM_W-1:0]  lo;
      logic [ROM_W-1:0]  delta;
      logic [LIM_W-1:0]  r;
   } st4_type;

   typedef struct packed {
      carry_type         c;
      logic [ROM_W-1:0]  lo;
      logic [NUM_W-1:0]  num;
   } st5_type;

   typedef struct packed {
      carry_type         c;
      logic [ROM_W-1:0]  lo;
      logic [NUM_W-1:0]  num;
      logic [Q2_W-1:0]   est;
   } st6_type;

   typedef struct packed {
      carry_type         c;
      logic [ROM_W-1:0]  sabs;
   } st7_type;

   typedef struct packed {
      carry_type              c;
      logic signed [S_W-1:0]  s;
   } st8_type;

   typedef struct packed {
      mode_type                  mode;
      logic signed [S_W-1:0]     s;
      logic signed [XS_W-1:0]    xs;
      logic signed [DATA_W-1:0]  gate;
      logic signed [DATA_W-1:0]  grad;
      logic signed [GG_W-1:0]    ggr;
   } st9_type;

   typedef struct packed {
      mode_type                  mode;
      logic signed [S_W-1:0]     s;
      logic signed [T_W-1:0]     t;
      logic signed [XSG_W-1:0]   xsg;
      logic signed [XSG_W-1:0]   ggp;
      logic signed [GG_W-1:0]    ggr;
   } st10_type;

   typedef struct packed {
      mode_type                  mode;
      logic signed [SD_W-1:0]    sd;
      logic signed [GG_W-1:0]    ggr;
      sat_type                   fwd;
      sat_type                   gg;
   } st11_type;

   typedef struct packed {
      mode_type                  mode;
      logic signed [GX_W-1:0]    gx;
      sat_type                   fwd;
      sat_type                   gg;
   } st12_type;

   logic [PIPE_STAGES-1:0] valid_ff, valid_in;
   st1_type  st1_ff,  st1_in;
   st2_type  st2_ff,  st2_in;
   st3_type  st3_ff,  st3_in;
   st4_type  st4_ff,  st4_in;
   st5_type  st5_ff,  st5_in;
   st6_type  st6_ff,  st6_in;
   st7_type  st7_ff,  st7_in;
   st8_type  st8_ff,  st8_in;
   st9_type  st9_ff,  st9_in;
   st10_type st10_ff, st10_in;
   st11_type st11_ff, st11_in;
   st12_type st12_ff, st12_in;

   logic [PROD1_W-1:0] prod1;
   logic [POS_W-1:0]   rem1;
   logic               cap;
   logic [IDX_W-1:0]   hi_idx;
   logic [ROM_W-1:0]   lo_val;
   logic [ROM_W-1:0]   hi_val;
   logic [PROD2_W-1:0] prod2;
   logic [NUM_W-1:0]   rem2;
   logic [Q2_W-1:0]    q2;
   sat_type            gx_sat;
   result_type         result;

   result_type        out_ff [OUT_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  inflight_ff, inflight_in;
   logic              out_pop;
   logic              out_push;

   // issue only when a queue slot is reserved for the item
   assign q_pop    = !q_empty && (inflight_ff < CNT_W'(OUT_DEPTH));
   assign out_pop  = rsp_pop && !rsp_empty;
   assign out_push = valid_ff[PIPE_STAGES-1];

   always_comb begin
      valid_in = {valid_ff[PIPE_STAGES-2:0], q_pop};
   end

   // position in the table: idx = pos / LIM, r = pos % LIM
   always_comb begin
      st1_in.c   = q_item.c;
      st1_in.pos = POS_W'(q_item.x_abs) * POS_W'(SIGMOID_ENTRIES);

      prod1      = PROD1_W'(st1_ff.pos) * PROD1_W'(RCP1);
      st2_in.c   = st1_ff.c;
      st2_in.pos = st1_ff.pos;
      st2_in.est = prod1[POS_W +: IDX_W];

      rem1     = st2_ff.pos - POS_W'(st2_ff.est) * POS_W'(LIM);
      st3_in.c = st2_ff.c;
      if (rem1 >= POS_W'(LIM)) begin
         st3_in.idx = st2_ff.est + IDX_W'(1);
         st3_in.r   = LIM_W'(rem1 - POS_W'(LIM));
      end else begin
         st3_in.idx = st2_ff.est;
         st3_in.r   = LIM_W'(rem1);
      end
   end

   // table lookup; at the last sample the step is zero
   always_comb begin
      cap          = (st3_ff.idx >= IDX_W'(SIGMOID_ENTRIES));
      hi_idx       = cap ? st3_ff.idx : st3_ff.idx + IDX_W'(1);
      lo_val       = SIG_ROM[st3_ff.idx];
      hi_val       = SIG_ROM[hi_idx];
      st4_in.c     = st3_ff.c;
      st4_in.lo    = lo_val;
      st4_in.r     = st3_ff.r;
      st4_in.delta = (!cap && hi_val >= lo_val) ? hi_val - lo_val : '0;

      st5_in.c   = st4_ff.c;
      st5_in.lo  = st4_ff.lo;
      st5_in.num = NUM_W'(st4_ff.delta) * NUM_W'(st4_ff.r) + NUM_W'(HALF_LIM);

      prod2      = PROD2_W'(st5_ff.num) * PROD2_W'(RCP2);
      st6_in.c   = st5_ff.c;
      st6_in.lo  = st5_ff.lo;
      st6_in.num = st5_ff.num;
      st6_in.est = prod2[NUM_W +: Q2_W];

      rem2        = st6_ff.num - NUM_W'(st6_ff.est) * NUM_W'(LIM);
      q2          = (rem2 >= NUM_W'(LIM)) ? st6_ff.est + Q2_W'(1) : st6_ff.est;
      st7_in.c    = st6_ff.c;
      st7_in.sabs = st6_ff.lo + ROM_W'(q2);

      st8_in.c = st7_ff.c;
      st8_in.s = st7_ff.c.x_neg ? S_W'(ONE) - $signed(S_W'(st7_ff.sabs))
                                : $signed(S_W'(st7_ff.sabs));
   end

   // products, one multiplier level per stage
   always_comb begin
      st9_in.mode = st8_ff.c.mode;
      st9_in.s    = st8_ff.s;
      st9_in.gate = st8_ff.c.gate;
      st9_in.grad = st8_ff.c.grad;
      st9_in.xs   = XS_W'(st8_ff.c.x) * XS_W'(st8_ff.s);
      st9_in.ggr  = GG_W'(st8_ff.c.grad) * GG_W'(st8_ff.c.gate);

      st10_in.mode = st9_ff.mode;
      st10_in.s    = st9_ff.s;
      st10_in.ggr  = st9_ff.ggr;
      st10_in.t    = T_W'(st9_ff.xs) * T_W'(S_W'(ONE) - st9_ff.s);
      st10_in.xsg  = XSG_W'(st9_ff.xs) * XSG_W'(st9_ff.gate);
      st10_in.ggp  = XSG_W'(st9_ff.grad) * XSG_W'(st9_ff.xs);

      // silu derivative with 2*FRAC_BITS fraction bits
      st11_in.mode = st10_ff.mode;
      st11_in.ggr  = st10_ff.ggr;
      st11_in.sd   = SD_W'((WIDE_W'(st10_ff.s) <<< FRAC_BITS)
                           + rnd_shift(WIDE_W'(st10_ff.t), FRAC_BITS));
      st11_in.fwd  = rnd_sat(WIDE_W'(st10_ff.xsg), 2 * FRAC_BITS);
      st11_in.gg   = rnd_sat(WIDE_W'(st10_ff.ggp), 2 * FRAC_BITS);

      st12_in.mode = st11_ff.mode;
      st12_in.fwd  = st11_ff.fwd;
      st12_in.gg   = st11_ff.gg;
      st12_in.gx   = GX_W'(st11_ff.ggr) * GX_W'(st11_ff.sd);
   end

   always_comb begin
      gx_sat = rnd_sat(WIDE_W'(st12_ff.gx), 3 * FRAC_BITS);
      if (st12_ff.mode == MODE_BWD) begin
         result.primary   = gx_sat.value;
         result.dgate     = st12_ff.gg.value;
         result.saturated = gx_sat.clip || st12_ff.gg.clip;
      end else begin
         result.primary   = st12_ff.fwd.value;
         result.dgate     = '0;
         result.saturated = st12_ff.fwd.clip;
      end
   end

   always_comb begin
      wr_ptr_in   = out_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in   = out_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in    = count_ff + CNT_W'(out_push) - CNT_W'(out_pop);
      inflight_in = inflight_ff + CNT_W'(q_pop) - CNT_W'(out_pop);
   end

   assign rsp_empty       = (count_ff == '0);
   assign rsp_primary_out = out_ff[rd_ptr_ff].primary;
   assign rsp_dgate_out   = out_ff[rd_ptr_ff].dgate;
   assign rsp_saturated   = out_ff[rd_ptr_ff].saturated;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         inflight_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         inflight_ff <= inflight_in;
      end
   end

   always_ff @(posedge clock) begin
      st1_ff  <= st1_in;
      st2_ff  <= st2_in;
      st3_ff  <= st3_in;
      st4_ff  <= st4_in;
      st5_ff  <= st5_in;
      st6_ff  <= st6_in;
      st7_ff  <= st7_in;
      st8_ff  <= st8_in;
      st9_ff  <= st9_in;
      st10_ff <= st10_in;
      st11_ff <= st11_in;
      st12_ff <= st12_in;
      if (out_push) begin
         out_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

### rtl/swiglu_forward_backward.sv
// Top level of the SwiGLU forward/backward unit: mode register, front end and back end.
//
//  port group   direction  handshake            payload
//  req_*        in         push / full          x_in, gate_in, grad_in (Q5.10)
//  rsp_*        out        pop / empty          primary_out, dgate_out, saturated
//  csr_*        in         write, no wait       wdata bit 0 = mode (0 fwd, 1 bwd)
//
// One item per cycle sustained while result-queue slots are free; latency from push to a
// non-empty result is set by the 12-stage back-end pipeline plus the front and result queues.
// The back end issues only when a result-queue slot is free, so a stalled pop
// backs up into the 4-entry front queue, which then raises full.
// Synchronous active-high reset empties both queues and sets mode to forward.
module swiglu_forward_backward
   import swg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  logic signed [DATA_W-1:0]  req_x_in,
   input  logic signed [DATA_W-1:0]  req_gate_in,
   input  logic signed [DATA_W-1:0]  req_grad_in,
   output logic                      req_full,
   input  logic                      rsp_pop,
   output logic                      rsp_empty,
   output logic signed [DATA_W-1:0]  rsp_primary_out,
   output logic signed [DATA_W-1:0]  rsp_dgate_out,
   output logic                      rsp_saturated,
   input  logic                      csr_write,
   input  logic                      csr_wdata
);

   mode_type       mode_ff, mode_in;
   logic           q_pop;
   logic           q_empty;
   front_item_type q_item;

   assign mode_in = csr_write ? mode_type'(csr_wdata) : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_FWD;
      end else begin
         mode_ff <= mode_in;
      end
   end

   swg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .mode        (mode_ff),
      .req_push    (req_push),
      .req_x_in    (req_x_in),
      .req_gate_in (req_gate_in),
      .req_grad_in (req_grad_in),
      .req_full    (req_full),
      .q_pop       (q_pop),
      .q_empty     (q_empty),
      .q_item      (q_item)
   );

   swg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_item          (q_item),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_primary_out (rsp_primary_out),
      .rsp_dgate_out   (rsp_dgate_out),
      .rsp_saturated   (rsp_saturated)
   );

endmodule
